// ===== sv/smmf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smmf_pkg: shared types and constants of the sliding median / min-max filter
// Window depth, field widths, reset extremes and the link between cells.
// ----------------------------------------------------------------------------
package smmf_pkg;

    localparam int WINDOW    = 7;
    localparam int SAMPLE_W  = 12;
    localparam int AGE_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int MED_IDX   = (WINDOW - 1) / 2;
    localparam int IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((3 * SAMPLE_W + 7) / 8) * 8;

    localparam logic [SAMPLE_W-1:0] MAX_RESET = SAMPLE_W'(174);
    localparam logic [SAMPLE_W-1:0] MIN_RESET = SAMPLE_W'(1205);
    localparam logic [AGE_W-1:0]    AGE_OLDEST = AGE_W'(WINDOW - 1);

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [AGE_W-1:0]    t_age;

    // What one cell shows its neighbors
    typedef struct packed {
        t_sample value;     // current sorted value
        t_age    age;       // items since this value entered
        logic    gt;        // value is greater than the incoming sample
        logic    old_incl;  // oldest entry sits in this cell or below
    } t_link;

    typedef enum logic [1:0] {
        SEL_OWN,
        SEL_LO,
        SEL_HI,
        SEL_NEW
    } t_sel;

endpackage

// ===== sv/sliding_median_minmax_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_median_minmax_filter: 7-sample running median with running extremes
// Sorted cell chain for the median, two compare registers for max and min.
// ----------------------------------------------------------------------------
// One item in, one result out. Each accepted sample enters a chain of WINDOW
// cells that keep the window sorted, each cell tagged with its age; the
// oldest sample drops out and the new one lands in its sorted place in the
// same cycle, so the block takes one item per clock unless the output stalls.
// The median is read from the middle cell (lower middle for an even window).
// The running maximum starts at 174 and the running minimum at 1205; each
// moves only on a strictly larger or smaller sample, independently. The
// window starts as all zeros, so early medians count those zeros. A result
// sits in an output register; a new item is accepted whenever that register
// is empty or is being taken, so a full stall holds the input.
// ----------------------------------------------------------------------------
module sliding_median_minmax_filter (
    input  logic i_clk,
    input  logic i_rst_n,
    // input item: [11:0] sample, [15:12] zero
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [smmf_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // result item: [11:0] median, [23:12] running_max, [35:24] running_min,
    // [39:36] zero
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [smmf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import smmf_pkg::*;

    t_sample w_sample;
    logic    w_accept;
    t_link   w_link [WINDOW];
    t_sample w_next [WINDOW];
    t_link   w_lo_edge, w_hi_edge;

    t_sample r_max, n_max;
    t_sample r_min, n_min;
    t_sample r_median;
    logic    r_valid;

    assign w_sample      = s_axis_tdata[SAMPLE_W-1:0];
    assign s_axis_tready = !r_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // chain ends: nothing older below the first cell, everything above the last
    assign w_lo_edge = '{value: '0, age: '0, gt: 1'b0, old_incl: 1'b0};
    assign w_hi_edge = '{value: '0, age: '0, gt: 1'b1, old_incl: 1'b0};

    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        smmf_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_load       (w_accept),
            .i_sample     (w_sample),
            .i_init_age   (t_age'(g)),
            .i_from_lo    ((g == 0) ? w_lo_edge : w_link[(g == 0) ? 0 : g - 1]),
            .i_from_hi    ((g == WINDOW - 1) ? w_hi_edge
                                             : w_link[(g == WINDOW - 1) ? g : g + 1]),
            .o_link       (w_link[g]),
            .o_next_value (w_next[g])
        );
    end

    // extremes move independently, strict compare each
    assign n_max = (w_sample > r_max) ? w_sample : r_max;
    assign n_min = (w_sample < r_min) ? w_sample : r_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max   <= MAX_RESET;
            r_min   <= MIN_RESET;
            r_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_max <= n_max;
                r_min <= n_min;
            end
            // hold the result until taken, refill on the same edge
            if (w_accept)          r_valid <= 1'b1;
            else if (m_axis_tready) r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_median <= w_next[MED_IDX];
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_min, r_max, r_median});

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic [WINDOW-1:0] w_oldest_vec;
    logic              w_sorted;

    always_comb begin
        w_sorted = 1'b1;
        for (int k = 0; k < WINDOW; k++) begin
            w_oldest_vec[k] = (w_link[k].age == AGE_OLDEST);
        end
        for (int k = 0; k < WINDOW - 1; k++) begin
            if (w_link[k].value > w_link[k + 1].value) w_sorted = 1'b0;
        end
    end

    a_one_oldest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(w_oldest_vec))
        else $error("window does not hold exactly one oldest entry");

    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sorted)
        else $error("cell chain is not sorted");

    a_max_rises: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_max >= $past(r_max)) && (r_min <= $past(r_min)))
        else $error("running extreme moved the wrong way");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_valid && (r_median == $past(w_next[MED_IDX])))
        else $error("accepted item produced no matching result");

endmodule

// ===== sv/smmf_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smmf_cell: one slot of the sorted window
// Holds one value and its age; on each item keeps, shifts from a neighbor,
// or takes the new sample so the chain stays sorted without the oldest entry.
// ----------------------------------------------------------------------------
module smmf_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  smmf_pkg::t_sample i_sample,
    input  smmf_pkg::t_age   i_init_age,
    input  smmf_pkg::t_link  i_from_lo,
    input  smmf_pkg::t_link  i_from_hi,
    output smmf_pkg::t_link  o_link,
    output smmf_pkg::t_sample o_next_value
);
    import smmf_pkg::*;

    t_sample r_value, n_value;
    t_age    r_age, n_age;
    logic    w_gt, w_oldest;
    t_sel    w_sel;

    assign w_gt     = r_value > i_sample;
    assign w_oldest = (r_age == AGE_OLDEST);

    always_comb begin
        if (i_from_lo.old_incl) begin
            // oldest entry below: everything above it slides down
            if (!i_from_hi.gt)      w_sel = SEL_HI;
            else if (w_gt)          w_sel = SEL_OWN;
            else                    w_sel = SEL_NEW;
        end else if (w_oldest) begin
            if (!i_from_hi.gt)      w_sel = SEL_HI;
            else if (i_from_lo.gt)  w_sel = SEL_LO;
            else                    w_sel = SEL_NEW;
        end else begin
            // oldest entry above: everything below it slides up
            if (!w_gt)              w_sel = SEL_OWN;
            else if (i_from_lo.gt)  w_sel = SEL_LO;
            else                    w_sel = SEL_NEW;
        end
    end

    always_comb begin
        unique case (w_sel)
            SEL_OWN: begin
                n_value = r_value;
                n_age   = r_age + t_age'(1);
            end
            SEL_LO: begin
                n_value = i_from_lo.value;
                n_age   = i_from_lo.age + t_age'(1);
            end
            SEL_HI: begin
                n_value = i_from_hi.value;
                n_age   = i_from_hi.age + t_age'(1);
            end
            default: begin
                n_value = i_sample;
                n_age   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
            r_age   <= i_init_age;
        end else if (i_load) begin
            r_value <= n_value;
            r_age   <= n_age;
        end
    end

    assign o_link.value    = r_value;
    assign o_link.age      = r_age;
    assign o_link.gt       = w_gt;
    assign o_link.old_incl = i_from_lo.old_incl | w_oldest;
    assign o_next_value    = n_value;

endmodule
